// ----- hw/rtl/ssm_pkg.sv -----
// ----------------------------------------------------------------------------
// ssm_pkg
// Shared types and constants of the sound slot mixer: item kinds, status
// codes, controller states and the command/status groups between modules.
// ----------------------------------------------------------------------------
package ssm_pkg;

  // pcm limits
  localparam logic signed [15:0] PCM_MAX = 16'sh7fff;
  localparam logic signed [15:0] PCM_MIN = -16'sh8000;

  // field widths of one beat
  localparam int unsigned ACT_W    = 2;
  localparam int unsigned ADDR_W   = 16;
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned START_W  = 16;
  localparam int unsigned LEN_W    = 17;
  localparam int unsigned STAT_W   = 2;
  localparam int unsigned CNT_W    = 3;

  // item kinds carried in tuser
  typedef enum logic [ACT_W-1:0] {
    ACT_LOAD  = 2'd0,
    ACT_QUEUE = 2'd1,
    ACT_TICK  = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_NO_SLOT = 2'd1,
    STAT_EMPTY   = 2'd2
  } status_e;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_ACC,
    S_DONE
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic capture;   // take the input beat
    logic exec;      // perform load / queue, start a tick
    logic rd;        // read the current voice sample
    logic acc;       // accumulate and advance the current voice
    logic out_load;  // fill the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    action_e action;
    logic    last_voice;
  } sts_t;

endpackage

// ----- hw/rtl/ssm_ctrl.sv -----
// ----------------------------------------------------------------------------
// ssm_ctrl
// Controller of the sound slot mixer: sequences one item at a time through
// execute, per-voice read/accumulate and result handoff.
// ----------------------------------------------------------------------------
module ssm_ctrl
  import ssm_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        state_d = (sts_i.action == ACT_TICK) ? S_READ : S_DONE;
      end
      S_READ: begin
        state_d = S_ACC;
      end
      S_ACC: begin
        state_d = sts_i.last_voice ? S_DONE : S_READ;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // command outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
      end
      S_READ: begin
        cmd_o.rd = 1'b1;
      end
      S_ACC: begin
        cmd_o.acc = 1'b1;
      end
      S_DONE: begin
        cmd_o.out_load = !out_valid_q || out_ready_i;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  // output register valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- hw/rtl/ssm_datapath.sv -----
// ----------------------------------------------------------------------------
// ssm_datapath
// Datapath of the sound slot mixer: sample memory, voice slot registers,
// saturating accumulator and the output register.
// ----------------------------------------------------------------------------
module ssm_datapath
  import ssm_pkg::*;
#(
  parameter int unsigned VOICES       = 4,
  parameter int unsigned SAMPLE_WORDS = 65536
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  cmd_t                       cmd_i,
  output sts_t                       sts_o,
  input  logic [ACT_W-1:0]           action_i,
  input  logic [ADDR_W-1:0]          address_i,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  input  logic [START_W-1:0]         sound_start_i,
  input  logic [LEN_W-1:0]           sound_length_i,
  output logic signed [SAMPLE_W-1:0] mixed_sample_o,
  output logic [STAT_W-1:0]          status_o,
  output logic [CNT_W-1:0]           active_voices_o
);

  localparam int unsigned AW    = $clog2(SAMPLE_WORDS);
  localparam int unsigned VW    = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int unsigned CNTW  = (VOICES >= 7) ? $clog2(VOICES + 1) : 3;
  localparam int unsigned RSUMW = AW + LEN_W + 1;
  localparam int unsigned LSUMW = AW + ADDR_W;

  // captured item
  action_e                    act_q;
  logic [ADDR_W-1:0]          addr_q;
  logic signed [SAMPLE_W-1:0] sample_q;
  logic [START_W-1:0]         start_q;
  logic [LEN_W-1:0]           len_q;

  // voice slots
  logic [VOICES-1:0]  active_q;
  logic [START_W-1:0] v_start_q [VOICES];
  logic [LEN_W-1:0]   v_len_q   [VOICES];
  logic [LEN_W-1:0]   v_pos_q   [VOICES];

  // tick working registers
  logic [VW-1:0]              v_q;
  logic signed [SAMPLE_W-1:0] mix_q;
  logic signed [SAMPLE_W-1:0] rd_data_q;
  status_e                    status_q;

  // sample memory
  logic [SAMPLE_W-1:0] mem [2**AW];

  logic [LSUMW-1:0]         ld_sum;
  logic [AW-1:0]            ld_addr;
  logic [RSUMW-1:0]         rd_sum;
  logic [AW-1:0]            rd_addr;
  logic [LEN_W-1:0]         pos_nxt;
  logic signed [SAMPLE_W:0] add_sum;
  logic signed [SAMPLE_W-1:0] mix_sat;
  logic                     free_any;
  logic [VW-1:0]            free_idx;
  logic [CNTW-1:0]          cnt;
  logic                     claim;

  // memory addresses, wrapped to the memory size
  assign ld_sum  = LSUMW'(addr_q);
  assign ld_addr = ld_sum[AW-1:0];
  assign rd_sum  = RSUMW'(v_start_q[v_q]) + RSUMW'(v_pos_q[v_q]);
  assign rd_addr = rd_sum[AW-1:0];

  // next position of the current voice
  assign pos_nxt = v_pos_q[v_q] + LEN_W'(1);

  // saturating add of the fetched sample
  always_comb begin
    add_sum = {mix_q[SAMPLE_W-1], mix_q} + {rd_data_q[SAMPLE_W-1], rd_data_q};
    if (add_sum > (SAMPLE_W+1)'(PCM_MAX)) begin
      mix_sat = PCM_MAX;
    end else if (add_sum < (SAMPLE_W+1)'(PCM_MIN)) begin
      mix_sat = PCM_MIN;
    end else begin
      mix_sat = add_sum[SAMPLE_W-1:0];
    end
  end

  // lowest free slot
  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = VOICES - 1; i >= 0; i--) begin
      if (!active_q[i]) begin
        free_any = 1'b1;
        free_idx = VW'(i);
      end
    end
  end

  assign claim = cmd_i.exec && (act_q == ACT_QUEUE) && (len_q != '0) && free_any;

  // occupied slot count
  always_comb begin
    cnt = '0;
    for (int i = 0; i < VOICES; i++) begin
      cnt = cnt + CNTW'(active_q[i]);
    end
  end

  // input capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      act_q    <= action_e'(action_i);
      addr_q   <= address_i;
      sample_q <= sample_i;
      start_q  <= sound_start_i;
      len_q    <= sound_length_i;
    end
  end

  // sample memory write and registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && (act_q == ACT_LOAD)) begin
      mem[ld_addr] <= sample_q;
    end
    if (cmd_i.rd) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  // slot occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
    end else if (claim) begin
      active_q[free_idx] <= 1'b1;
    end else if (cmd_i.acc && active_q[v_q] && (pos_nxt >= v_len_q[v_q])) begin
      active_q[v_q] <= 1'b0;
    end
  end

  // slot payload and tick working state
  always_ff @(posedge clk_i) begin
    if (claim) begin
      v_start_q[free_idx] <= start_q;
      v_len_q[free_idx]   <= len_q;
      v_pos_q[free_idx]   <= '0;
    end
    if (cmd_i.exec) begin
      v_q   <= '0;
      mix_q <= '0;
      if (act_q != ACT_QUEUE) begin
        status_q <= STAT_OK;
      end else if (len_q == '0) begin
        status_q <= STAT_EMPTY;
      end else if (free_any) begin
        status_q <= STAT_OK;
      end else begin
        status_q <= STAT_NO_SLOT;
      end
    end
    if (cmd_i.acc) begin
      v_q <= v_q + VW'(1);
      if (active_q[v_q]) begin
        mix_q        <= mix_sat;
        v_pos_q[v_q] <= pos_nxt;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      mixed_sample_o  <= (act_q == ACT_TICK) ? mix_q : '0;
      status_o        <= status_q;
      active_voices_o <= (cnt > CNTW'(7)) ? CNT_W'(7) : cnt[CNT_W-1:0];
    end
  end

  assign sts_o.action     = act_q;
  assign sts_o.last_voice = (v_q == VW'(VOICES - 1));

endmodule

// ----- hw/rtl/sound_slot_mixer.sv -----
// ----------------------------------------------------------------------------
// sound_slot_mixer
// Saturating mixer of signed 16-bit mono pcm with a fixed set of voice slots.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats arrive on the s_axis group. tuser says what a beat is: load
//   writes one word to sample memory, queue claims the lowest free voice slot
//   for a sound (start address, length), tick mixes one output sample.
//   Every input beat gives exactly one result beat on the m_axis group with
//   the mixed sample (zero unless tick), a status code and the slot count.
//   One item is worked on at a time. Load, queue and unused kinds pass
//   through capture, execute and result handoff; a tick in addition does
//   one sample memory read and one saturating add per voice slot in turn
//   between execute and handoff. The next beat is accepted only once the
//   previous item has been handed off to the output register.
//   The result waits in an output register; the next item is accepted while
//   it waits, but cannot finish until the receiver takes the earlier result.
//   Reset frees all voice slots and empties the output register; sample
//   memory is not cleared and must be loaded before it is played.
//   SAMPLE_WORDS is a power of two; addresses wrap modulo its value.
// ----------------------------------------------------------------------------
module sound_slot_mixer
  import ssm_pkg::*;
#(
  parameter int unsigned VOICES       = 4,
  parameter int unsigned SAMPLE_WORDS = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [15:0] address, [31:16] sample, [47:32] sound_start, [64:48] sound_length
  input  logic [71:0] s_axis_tdata_i,
  // [1:0] action
  input  logic [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [15:0] mixed_sample, [17:16] status, [20:18] active_voices
  output logic [23:0] m_axis_tdata_o
);

  cmd_t                       cmd;
  sts_t                       sts;
  logic signed [SAMPLE_W-1:0] mixed_sample;
  logic [STAT_W-1:0]          status;
  logic [CNT_W-1:0]           active_voices;

  // sequencer
  ssm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // memory, slots and mix
  ssm_datapath #(
    .VOICES       (VOICES),
    .SAMPLE_WORDS (SAMPLE_WORDS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .action_i        (s_axis_tuser_i),
    .address_i       (s_axis_tdata_i[15:0]),
    .sample_i        (s_axis_tdata_i[31:16]),
    .sound_start_i   (s_axis_tdata_i[47:32]),
    .sound_length_i  (s_axis_tdata_i[64:48]),
    .mixed_sample_o  (mixed_sample),
    .status_o        (status),
    .active_voices_o (active_voices)
  );

  // result beat packing
  assign m_axis_tdata_o = {3'b000, active_voices, status, mixed_sample};

endmodule

// ----- hw/rtl/ssm_checker.sv -----
// ----------------------------------------------------------------------------
// ssm_checker
// Port-level checks of the sound slot mixer, bound to the top level.
// ----------------------------------------------------------------------------
module ssm_checker
  import ssm_pkg::*;
#(
  parameter int unsigned VOICES = 4
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_tvalid_i,
  input logic        s_tready_i,
  input logic        m_tvalid_i,
  input logic        m_tready_i,
  input logic [23:0] m_tdata_i
);

  localparam logic [2:0] FULL_CNT = (VOICES > 7) ? 3'd7 : 3'(VOICES);

  // stalled result beat holds its data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && !m_tready_i |=> m_tvalid_i && $stable(m_tdata_i))
    else $error("result beat changed while stalled");

  // one item at a time: ready drops after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid_i && s_tready_i |=> !s_tready_i)
    else $error("input accepted while an item is in progress");

  // status code is a known one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i |-> m_tdata_i[17:16] != 2'd3)
    else $error("unknown status code");

  // no free slot only when every slot is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && (m_tdata_i[17:16] == STAT_NO_SLOT) |-> m_tdata_i[20:18] == FULL_CNT)
    else $error("slot refused while a slot was free");

  // a rejected queue beat carries no mix
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && (m_tdata_i[17:16] != STAT_OK) |-> m_tdata_i[15:0] == 16'd0)
    else $error("nonzero mix on a rejected item");

endmodule

bind sound_slot_mixer ssm_checker #(
  .VOICES (VOICES)
) u_ssm_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tvalid_i (s_axis_tvalid_i),
  .s_tready_i (s_axis_tready_o),
  .m_tvalid_i (m_axis_tvalid_o),
  .m_tready_i (m_axis_tready_i),
  .m_tdata_i  (m_axis_tdata_o)
);
